@@ src/jdc_pkg.sv @@
// Shared constants, types and helper functions for the Julian date to calendar converter.
package jdc_pkg;

	// Default fraction width of the incoming Julian date.
	localparam int FRAC_BITS_DEF = 24;

	// Field widths of the input and result transactions.
	localparam int JD_W     = 47;
	localparam int YEAR_W   = 16;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;

	// First day number of the Gregorian calendar.
	localparam int GREG_SWITCH = 2299161;

	// Scaled integer forms of the calendar constants.
	localparam int ALPHA_OFS      = 7468865;  // 4 * 1867216.25
	localparam int ALPHA_DIV      = 146097;   // 4 * 36524.25
	localparam int B_OFS          = 1524;
	localparam int C_OFS          = 12210;    // 100 * 122.1
	localparam int C_DIV          = 36525;    // 100 * 365.25
	localparam int D_MUL          = 1461;     // 4 * 365.25
	localparam int E_MUL          = 10000;
	localparam int E_DIV          = 306001;   // 10000 * 30.6001
	localparam int YEAR_OFS_LATE  = 4716;
	localparam int YEAR_OFS_EARLY = 4715;
	localparam int MONTH_WRAP     = 14;
	localparam int MONTH_LATE_OFS = 13;
	localparam int MONTH_MARCH    = 3;

	// Day count left over after whole years stays below 512.
	localparam int BD_W = 9;

	// Quotient bits resolved per pipeline stage of a constant divider.
	localparam int DIV_STEPS = 4;

	// floor(30.6001 * e) for every value of the five-bit month index.
	localparam logic [9:0] MDAY_OFS [32] = '{
		10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
		10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459,
		10'd489, 10'd520, 10'd550, 10'd581, 10'd612, 10'd642, 10'd673, 10'd703,
		10'd734, 10'd765, 10'd795, 10'd826, 10'd856, 10'd887, 10'd918, 10'd948
	};

	// Quotient width of an unsigned num_w-bit dividend over a constant divisor.
	function automatic int quo_w(input int num_w, input int divisor);
		return num_w - $clog2(divisor + 1) + 1;
	endfunction

endpackage

@@ src/jdc_if.sv @@
// Valid/ready channel interfaces for Julian date input and calendar result transactions.
interface jdc_in_if;
	logic                       valid;
	logic                       ready;
	logic [jdc_pkg::JD_W-1:0]   julian_date;

	modport source (output valid, output julian_date, input ready);
	modport sink   (input valid, input julian_date, output ready);
endinterface

interface jdc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [jdc_pkg::YEAR_W-1:0] year;
	logic [jdc_pkg::MONTH_W-1:0]       month;
	logic [jdc_pkg::DAY_W-1:0]         day;
	logic [jdc_pkg::HOUR_W-1:0]        hour;
	logic [jdc_pkg::MINUTE_W-1:0]      minute;
	logic [jdc_pkg::SECOND_W-1:0]      second;

	modport source (output valid, output year, output month, output day, output hour,
		output minute, output second, input ready);
	modport sink   (input valid, input year, input month, input day, input hour,
		input minute, input second, output ready);
endinterface

@@ src/jdc_cdiv.sv @@
// Pipelined restoring divider by a constant, with a side payload carried alongside.
module jdc_cdiv #(
	parameter int NUM_W   = 26,
	parameter int DIVISOR = 146097,
	parameter int SIDE_W  = 1,
	localparam int QUO_W  = jdc_pkg::quo_w(NUM_W, DIVISOR),
	localparam int NSTG   = (QUO_W + jdc_pkg::DIV_STEPS - 1) / jdc_pkg::DIV_STEPS
) (
	input  logic              clk,
	input  logic [NSTG-1:0]   en,
	input  logic [NUM_W-1:0]  num,
	input  logic [SIDE_W-1:0] side_in,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);
	import jdc_pkg::*;

	localparam int REM_W = $clog2(DIVISOR);

	// Partial remainder, dividend bits still to shift in (quotient bits fill from the
	// bottom), and the payload that rides with the transaction.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [QUO_W-1:0]  work;
		logic [SIDE_W-1:0] side;
	} div_stage_t;

	div_stage_t src [NSTG];
	div_stage_t stg_s [NSTG];

	// The top dividend bits are already below the divisor and seed the remainder.
	assign src[0] = {REM_W'(num[NUM_W-1:QUO_W]), num[QUO_W-1:0], side_in};

	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		localparam int FIRST = s * DIV_STEPS;
		localparam int CNT   = (QUO_W - FIRST < DIV_STEPS) ? QUO_W - FIRST : DIV_STEPS;

		div_stage_t nxt;

		if (s > 0) begin : g_link
			assign src[s] = stg_s[s-1];
		end

		// Resolve up to DIV_STEPS quotient bits by compare and subtract.
		always_comb begin
			logic [REM_W:0] trial;
			logic           qbit;
			nxt = src[s];
			for (int i = 0; i < CNT; i++) begin
				trial = {nxt.rem, nxt.work[QUO_W-1]};
				qbit = (trial >= (REM_W+1)'(DIVISOR));
				nxt.work = {nxt.work[QUO_W-2:0], qbit};
				nxt.rem = qbit ? REM_W'(trial - (REM_W+1)'(DIVISOR)) : REM_W'(trial);
			end
		end

		always_ff @(posedge clk) begin
			if (en[s]) begin
				stg_s[s] <= nxt;
			end
		end
	end

	assign quo      = stg_s[NSTG-1].work;
	assign side_out = stg_s[NSTG-1].side;

endmodule

@@ src/jdc_pipe_ctrl.sv @@
// Valid tracking and per-stage load enables for the converter pipeline, with bubble collapsing.
module jdc_pipe_ctrl #(
	parameter int NSTG = 18
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [NSTG-1:0] en
);

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] vin;
	logic [NSTG:0]   rdy;

	// A stage can take new data when it is empty or its content moves on.
	always_comb begin
		rdy[NSTG] = out_ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = ~vld_q[i] | rdy[i+1];
		end
	end

	assign vin = {vld_q[NSTG-2:0], in_valid};
	assign en  = vin & rdy[NSTG-1:0];

	// Valid bits advance with their data; a held stage keeps its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vin & rdy[NSTG-1:0]) | (vld_q & ~rdy[NSTG-1:0]);
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NSTG-1];

endmodule

@@ src/julian_date_to_calendar_core.sv @@
// Julian date to calendar date and time of day converter, top level.
// Takes one Julian date transaction per cycle and returns year, month, day, hour, minute and
// second for each, in order. The pipeline holds three constant dividers (alpha, century
// count c, month index e) that resolve four quotient bits per stage. Throughput is one
// transaction per cycle while the output is ready, and a stalled output only holds the stages
// that are full, so bubbles still fill while a result waits. The Julian calendar is used
// before day 2299161, the Gregorian from then on; seconds are rounded to nearest and may
// read 60 with no carry into the minute.
module julian_date_to_calendar_core #(
	parameter int FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	jdc_in_if.sink    julian,
	jdc_out_if.source calendar
);
	import jdc_pkg::*;

	localparam int JDH_W = JD_W + 1;
	localparam int Z_W   = JDH_W - FRAC_BITS;
	localparam int X1_W  = (Z_W + 2 > 23) ? Z_W + 2 : 23;
	localparam int Q1_W  = quo_w(X1_W, ALPHA_DIV);
	localparam int K1    = (Q1_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int B_W   = Z_W + 1;
	localparam int X2_W  = B_W + 7;
	localparam int Q2_W  = quo_w(X2_W, C_DIV);
	localparam int K2    = (Q2_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int P_W   = Q2_W + 11;
	localparam int X3_W  = BD_W + 14;
	localparam int Q3_W  = quo_w(X3_W, E_DIV);
	localparam int K3    = (Q3_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int T1_W  = FRAC_BITS + 5;
	localparam int T2_W  = FRAC_BITS + 6;

	// Stage positions along the valid chain.
	localparam int ST1  = 0;
	localparam int ST2  = 1;
	localparam int DV1  = 2;
	localparam int ST3  = DV1 + K1;
	localparam int ST4  = ST3 + 1;
	localparam int DV2  = ST4 + 1;
	localparam int ST5  = DV2 + K2;
	localparam int ST6  = ST5 + 1;
	localparam int ST7  = ST6 + 1;
	localparam int DV3  = ST7 + 1;
	localparam int ST8  = DV3 + K3;
	localparam int NSTG = ST8 + 1;

	localparam logic [JDH_W-1:0] HALF_JD = JDH_W'(1) << (FRAC_BITS - 1);
	localparam logic [T2_W-1:0]  HALF_T  = T2_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} tod_t;

	typedef struct packed {
		logic                 greg;
		logic [Z_W-1:0]       z;
		logic [HOUR_W-1:0]    hour;
		logic [FRAC_BITS-1:0] frac;
	} side1_t;

	typedef struct packed {
		logic [B_W-1:0] b;
		tod_t           tod;
	} side2_t;

	typedef struct packed {
		logic [BD_W-1:0] bd;
		logic [Q2_W-1:0] c;
		tod_t            tod;
	} side3_t;

	logic [NSTG-1:0] en;

	// Handshake control for the whole pipeline.
	jdc_pipe_ctrl #(.NSTG(NSTG)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (julian.valid),
		.in_ready  (julian.ready),
		.out_valid (calendar.valid),
		.out_ready (calendar.ready),
		.en        (en)
	);

	// Stage 1: shift the day boundary to midnight and split day number and fraction.
	logic [JDH_W-1:0]     jd_sum;
	logic [Z_W-1:0]       z_s1;
	logic [FRAC_BITS-1:0] frac_s1;

	assign jd_sum = {1'b0, julian.julian_date} + HALF_JD;

	always_ff @(posedge clk) begin
		if (en[ST1]) begin
			z_s1    <= jd_sum[JDH_W-1:FRAC_BITS];
			frac_s1 <= jd_sum[FRAC_BITS-1:0];
		end
	end

	// Stage 2: Gregorian test, alpha dividend, and hours from the day fraction.
	logic                 greg;
	logic [T1_W-1:0]      t1;
	logic                 greg_s2;
	logic [X1_W-1:0]      x1_s2;
	logic [Z_W-1:0]       z_s2;
	logic [HOUR_W-1:0]    hour_s2;
	logic [FRAC_BITS-1:0] frac_s2;

	assign greg = (64'(z_s1) >= 64'(GREG_SWITCH));
	assign t1   = (T1_W'(frac_s1) << 4) + (T1_W'(frac_s1) << 3);

	always_ff @(posedge clk) begin
		if (en[ST2]) begin
			greg_s2 <= greg;
			x1_s2   <= greg ? (X1_W'(z_s1) << 2) - X1_W'(ALPHA_OFS) : '0;
			z_s2    <= z_s1;
			hour_s2 <= t1[T1_W-1:FRAC_BITS];
			frac_s2 <= t1[FRAC_BITS-1:0];
		end
	end

	// Century correction alpha.
	logic [Q1_W-1:0] alpha;
	side1_t          side1_in;
	side1_t          side1_out;

	assign side1_in = '{greg: greg_s2, z: z_s2, hour: hour_s2, frac: frac_s2};

	jdc_cdiv #(
		.NUM_W   (X1_W),
		.DIVISOR (ALPHA_DIV),
		.SIDE_W  ($bits(side1_t))
	) u_div_alpha (
		.clk      (clk),
		.en       (en[DV1 +: K1]),
		.num      (x1_s2),
		.side_in  (side1_in),
		.quo      (alpha),
		.side_out (side1_out)
	);

	// Stage 3: day count b, and minutes from the remaining fraction.
	logic [B_W-1:0]       b_ofs;
	logic [T2_W-1:0]      t2;
	logic [B_W-1:0]       b_s3;
	logic [HOUR_W-1:0]    hour_s3;
	logic [MINUTE_W-1:0]  minute_s3;
	logic [FRAC_BITS-1:0] frac_s3;

	assign b_ofs = side1_out.greg
		? B_W'(B_OFS + 1) + B_W'(alpha) - B_W'(alpha >> 2)
		: B_W'(B_OFS);
	assign t2 = (T2_W'(side1_out.frac) << 6) - (T2_W'(side1_out.frac) << 2);

	always_ff @(posedge clk) begin
		if (en[ST3]) begin
			b_s3      <= B_W'(side1_out.z) + b_ofs;
			hour_s3   <= side1_out.hour;
			minute_s3 <= t2[T2_W-1:FRAC_BITS];
			frac_s3   <= t2[FRAC_BITS-1:0];
		end
	end

	// Stage 4: dividend for c, and rounded seconds.
	logic [X2_W-1:0] b_ext;
	logic [T2_W-1:0] t3;
	logic [X2_W-1:0] x2_s4;
	side2_t          side2_s4;

	assign b_ext = X2_W'(b_s3);
	assign t3    = (T2_W'(frac_s3) << 6) - (T2_W'(frac_s3) << 2) + HALF_T;

	always_ff @(posedge clk) begin
		if (en[ST4]) begin
			x2_s4    <= (b_ext << 6) + (b_ext << 5) + (b_ext << 2) - X2_W'(C_OFS);
			side2_s4 <= '{b: b_s3,
				tod: '{hour: hour_s3, minute: minute_s3, second: t3[T2_W-1:FRAC_BITS]}};
		end
	end

	// Year count c.
	logic [Q2_W-1:0] c_quo;
	side2_t          side2_out;

	jdc_cdiv #(
		.NUM_W   (X2_W),
		.DIVISOR (C_DIV),
		.SIDE_W  ($bits(side2_t))
	) u_div_c (
		.clk      (clk),
		.en       (en[DV2 +: K2]),
		.num      (x2_s4),
		.side_in  (side2_s4),
		.quo      (c_quo),
		.side_out (side2_out)
	);

	// Stage 5: days in whole years, 1461 * c.
	logic [P_W-1:0]  prod_s5;
	logic [Q2_W-1:0] c_s5;
	logic [B_W-1:0]  b_s5;
	tod_t            tod_s5;

	always_ff @(posedge clk) begin
		if (en[ST5]) begin
			prod_s5 <= P_W'(c_quo) * P_W'(D_MUL);
			c_s5    <= c_quo;
			b_s5    <= side2_out.b;
			tod_s5  <= side2_out.tod;
		end
	end

	// Stage 6: days left in the year; the difference always fits in BD_W bits.
	logic [BD_W-1:0] bd_s6;
	logic [Q2_W-1:0] c_s6;
	tod_t            tod_s6;

	always_ff @(posedge clk) begin
		if (en[ST6]) begin
			bd_s6  <= b_s5[BD_W-1:0] - prod_s5[BD_W+1:2];
			c_s6   <= c_s5;
			tod_s6 <= tod_s5;
		end
	end

	// Stage 7: dividend for the month index.
	logic [X3_W-1:0] x3_s7;
	side3_t          side3_s7;

	always_ff @(posedge clk) begin
		if (en[ST7]) begin
			x3_s7    <= X3_W'(bd_s6) * X3_W'(E_MUL);
			side3_s7 <= '{bd: bd_s6, c: c_s6, tod: tod_s6};
		end
	end

	// Month index e.
	logic [Q3_W-1:0] e_quo;
	side3_t          side3_out;

	jdc_cdiv #(
		.NUM_W   (X3_W),
		.DIVISOR (E_DIV),
		.SIDE_W  ($bits(side3_t))
	) u_div_e (
		.clk      (clk),
		.en       (en[DV3 +: K3]),
		.num      (x3_s7),
		.side_in  (side3_s7),
		.quo      (e_quo),
		.side_out (side3_out)
	);

	// Stage 8: month, year and day of month into the output register.
	logic [Q3_W-1:0]         mon_full;
	logic [MONTH_W-1:0]      mon;
	logic [9:0]              mday_ofs;
	logic signed [YEAR_W-1:0] year_s8;
	logic [MONTH_W-1:0]      month_s8;
	logic [DAY_W-1:0]        day_s8;
	tod_t                    tod_s8;

	assign mon_full = (e_quo < Q3_W'(MONTH_WRAP))
		? e_quo - Q3_W'(1)
		: e_quo - Q3_W'(MONTH_LATE_OFS);
	assign mon      = mon_full[MONTH_W-1:0];
	assign mday_ofs = MDAY_OFS[e_quo];

	always_ff @(posedge clk) begin
		if (en[ST8]) begin
			month_s8 <= mon;
			year_s8  <= YEAR_W'(side3_out.c) - ((mon >= MONTH_W'(MONTH_MARCH))
				? YEAR_W'(YEAR_OFS_LATE) : YEAR_W'(YEAR_OFS_EARLY));
			day_s8   <= side3_out.bd[DAY_W-1:0] - mday_ofs[DAY_W-1:0];
			tod_s8   <= side3_out.tod;
		end
	end

	assign calendar.year   = year_s8;
	assign calendar.month  = month_s8;
	assign calendar.day    = day_s8;
	assign calendar.hour   = tod_s8.hour;
	assign calendar.minute = tod_s8.minute;
	assign calendar.second = tod_s8.second;

endmodule

@@ tb/julian_date_to_calendar_checker.sv @@
// Checker that predicts each calendar result from the accepted Julian dates and compares it.
module julian_date_to_calendar_checker #(
	parameter int FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	jdc_in_if    julian,
	jdc_out_if   calendar,
	output int   mismatches,
	output int   outstanding,
	output int   checked,
	output int   sixty_seconds,
	output int   julian_calendar_dates
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] TICKS_PER_DAY   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] FRAC_MASK       = TICKS_PER_DAY - 64'd1;
	localparam logic [63:0] HALF_DAY        = TICKS_PER_DAY >> 1;
	localparam logic [63:0] GREGORIAN_START = 64'd2299161;

	typedef struct packed {
		logic signed [jdc_pkg::YEAR_W-1:0] year;
		logic [jdc_pkg::MONTH_W-1:0]       month;
		logic [jdc_pkg::DAY_W-1:0]         day;
		logic [jdc_pkg::HOUR_W-1:0]        hour;
		logic [jdc_pkg::MINUTE_W-1:0]      minute;
		logic [jdc_pkg::SECOND_W-1:0]      second;
	} calendar_t;

	typedef struct {
		logic [jdc_pkg::JD_W-1:0] date;
		calendar_t                want;
	} pending_date_t;

	pending_date_t pending_dates[$];

	// Calendar date and time of day for one fixed-point Julian date.
	function automatic calendar_t julian_to_calendar(input logic [jdc_pkg::JD_W-1:0] date);
		logic [63:0] jd, whole, frac, alpha, adjusted, base, centuries, cent_days;
		logic [63:0] month_idx, month, day_of_month, year, t;
		calendar_t r;
		// Shift the day start from noon to midnight, then split whole days and fraction.
		jd    = 64'(date) + HALF_DAY;
		whole = jd >> FRAC_BITS;
		frac  = jd & FRAC_MASK;
		// Gregorian correction for the dropped century leap days.
		if (whole < GREGORIAN_START) begin
			adjusted = whole;
		end else begin
			alpha    = (64'd4 * whole - 64'd7468865) / 64'd146097;
			adjusted = whole + 64'd1 + alpha - alpha / 64'd4;
		end
		base         = adjusted + 64'd1524;
		centuries    = (64'd100 * base - 64'd12210) / 64'd36525;
		cent_days    = (64'd1461 * centuries) / 64'd4;
		month_idx    = (64'd10000 * (base - cent_days)) / 64'd306001;
		month        = (month_idx < 64'd14) ? month_idx - 64'd1 : month_idx - 64'd13;
		day_of_month = base - cent_days - (64'd306001 * month_idx) / 64'd10000;
		// Wrapping subtraction keeps the low bits of the signed year.
		year         = centuries - ((month > 64'd2) ? 64'd4716 : 64'd4715);
		r.year   = year[jdc_pkg::YEAR_W-1:0];
		r.month  = month[jdc_pkg::MONTH_W-1:0];
		r.day    = day_of_month[jdc_pkg::DAY_W-1:0];
		// Time of day: scale the fraction by 24, 60 and 60, rounding only the seconds.
		t        = frac * 64'd24;
		r.hour   = t[FRAC_BITS +: jdc_pkg::HOUR_W];
		t        = (t & FRAC_MASK) * 64'd60;
		r.minute = t[FRAC_BITS +: jdc_pkg::MINUTE_W];
		t        = (t & FRAC_MASK) * 64'd60 + HALF_DAY;
		r.second = t[FRAC_BITS +: jdc_pkg::SECOND_W];
		return r;
	endfunction

	// Compare one result field and report a difference.
	task automatic check_field(input string name, input logic [jdc_pkg::JD_W-1:0] date,
		input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch for date 0x%h: expected %0d, got %0d",
				$time, name, date, want, got);
		end
	endtask

	// Results are checked before new dates are queued, so a spurious result
	// can never be matched against a date accepted at the same edge.
	always @(posedge clk) begin : monitor
		calendar_t     got;
		pending_date_t head;
		if (arst_n) begin
			if (calendar.valid && calendar.ready) begin
				got = '{year: calendar.year, month: calendar.month, day: calendar.day,
					hour: calendar.hour, minute: calendar.minute, second: calendar.second};
				if (pending_dates.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, %s %0d-%0d-%0d %0d:%0d:%0d",
						$time, "got", got.year, got.month, got.day, got.hour, got.minute,
						got.second);
				end else begin
					head = pending_dates.pop_front();
					outstanding--;
					checked++;
					if (head.want.second == 6'd60) sixty_seconds++;
					check_field("year", head.date, longint'(head.want.year),
						longint'(got.year));
					check_field("month", head.date, longint'(head.want.month),
						longint'(got.month));
					check_field("day", head.date, longint'(head.want.day),
						longint'(got.day));
					check_field("hour", head.date, longint'(head.want.hour),
						longint'(got.hour));
					check_field("minute", head.date, longint'(head.want.minute),
						longint'(got.minute));
					check_field("second", head.date, longint'(head.want.second),
						longint'(got.second));
				end
			end
			if (julian.valid && julian.ready) begin
				pending_dates.push_back('{date: julian.julian_date,
					want: julian_to_calendar(julian.julian_date)});
				outstanding++;
				if (((64'(julian.julian_date) + HALF_DAY) >> FRAC_BITS) < GREGORIAN_START) begin
					julian_calendar_dates++;
				end
			end
		end
	end

endmodule

@@ tb/julian_date_to_calendar_core_tb.sv @@
// Testbench top for the Julian date to calendar converter: stimulus, flow control and verdict.
module julian_date_to_calendar_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS     = jdc_pkg::FRAC_BITS_DEF;
	localparam int RANDOM_DATES  = 1450;
	localparam int HOLD_DATES    = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_DATES   = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 40;

	localparam logic [63:0] TICKS_PER_DAY = 64'd1 << FRAC_BITS;
	localparam logic [63:0] HALF_DAY      = TICKS_PER_DAY >> 1;
	localparam logic [63:0] HALF_SECOND   = TICKS_PER_DAY / 64'd172800;
	localparam logic [63:0] LAST_DAY      = (64'd1 << (jdc_pkg::JD_W - FRAC_BITS)) - 64'd1;

	// Output-side flow control modes.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_PATTERN,
		RX_HOLD
	} rx_mode_t;

	logic     clk = 1'b0;
	logic     arst_n;
	rx_mode_t rx_mode = RX_FREE;

	int mismatches;
	int outstanding;
	int checked;
	int sixty_seconds;
	int julian_calendar_dates;

	jdc_in_if  julian ();
	jdc_out_if calendar ();

	julian_date_to_calendar_core #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.julian  (julian),
		.calendar(calendar)
	);

	julian_date_to_calendar_checker #(
		.FRAC_BITS(FRAC_BITS)
	) checker_inst (
		.clk                  (clk),
		.arst_n               (arst_n),
		.julian               (julian),
		.calendar             (calendar),
		.mismatches           (mismatches),
		.outstanding          (outstanding),
		.checked              (checked),
		.sixty_seconds        (sixty_seconds),
		.julian_calendar_dates(julian_calendar_dates)
	);

	// 4 ns clock.
	always begin
		#2ns clk = 1'b1;
		#2ns clk = 1'b0;
	end

	// Fixed-point Julian date whose midnight-based day number and fraction are given.
	function automatic logic [jdc_pkg::JD_W-1:0] date_at(input logic [63:0] day,
		input logic [63:0] frac);
		logic [63:0] v;
		v = (day << FRAC_BITS) + frac - HALF_DAY;
		return v[jdc_pkg::JD_W-1:0];
	endfunction

	// Random date drawn from a mix of full-range values, dates near the calendar
	// switch, times just short of a minute boundary and historical dates.
	function automatic logic [jdc_pkg::JD_W-1:0] random_date();
		logic [63:0] raw, day, frac;
		int          minute_idx;
		case ($urandom_range(0, 9))
			0, 1: begin
				raw = {$urandom(), $urandom()};
				return raw[jdc_pkg::JD_W-1:0];
			end
			2, 3: begin
				day  = 64'd2299161 + 64'($urandom_range(0, 800)) - 64'd400;
				frac = 64'($urandom()) & (TICKS_PER_DAY - 64'd1);
			end
			4, 5: begin
				day        = 64'($urandom_range(1, int'(LAST_DAY)));
				minute_idx = $urandom_range(0, 1439);
				frac       = (64'(minute_idx) + 64'd1) * 64'd60 * TICKS_PER_DAY / 64'd86400
					- 64'($urandom_range(0, int'(HALF_SECOND)));
				if (frac >= TICKS_PER_DAY) frac = TICKS_PER_DAY - 64'd1;
			end
			default: begin
				day  = 64'($urandom_range(1000000, 3000000));
				frac = 64'($urandom()) & (TICKS_PER_DAY - 64'd1);
			end
		endcase
		return date_at(day, frac);
	endfunction

	// Offer one date and hold it until the block takes it.
	task automatic offer(input logic [jdc_pkg::JD_W-1:0] date);
		julian.valid       <= 1'b1;
		julian.julian_date <= date;
		do @(posedge clk); while (!julian.ready);
		@(negedge clk);
	endtask

	// Idle the input for a number of cycles with junk on the payload.
	task automatic pause(input int cycles);
		julian.valid       <= 1'b0;
		julian.julian_date <= random_date();
		repeat (cycles) @(negedge clk);
	endtask

	// Idle the input until every queued result has come back.
	task automatic drain();
		julian.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Output ready: free running, a random stall pattern, or a long hold-off.
	initial begin : receiver
		rx_mode_t    seen;
		int          hold_left;
		int          phase;
		logic [15:0] mask;
		calendar.ready = 1'b0;
		seen           = RX_FREE;
		hold_left      = 0;
		phase          = 0;
		mask           = '1;
		forever begin
			@(negedge clk);
			if (rx_mode == RX_HOLD && seen != RX_HOLD) hold_left = HOLD_CYCLES;
			seen = rx_mode;
			case (rx_mode)
				RX_FREE: begin
					calendar.ready <= 1'b1;
				end
				RX_PATTERN: begin
					// A new 16-bit mask every pass; one in four has no stalls at all.
					if (phase == 0) begin
						mask = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom() | $urandom());
					end
					calendar.ready <= mask[phase];
					phase = (phase + 1) % 16;
				end
				default: begin
					calendar.ready <= (hold_left == 0);
					if (hold_left > 0) hold_left--;
				end
			endcase
		end
	end

	// Ends the run when no transaction has happened for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((julian.valid && julian.ready) || (calendar.valid && calendar.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus: directed dates, a long output hold-off, then random bursts.
	initial begin : stimulus
		logic [63:0] alternating;
		int          burst_left;
		int          gap;
		alternating        = {32{2'b01}};
		burst_left         = 0;
		julian.valid       = 1'b0;
		julian.julian_date = '0;
		arst_n             = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Field extremes, bit patterns and calendar corner cases.
		offer('0);
		offer({jdc_pkg::JD_W{1'b1}});
		offer(jdc_pkg::JD_W'(1));
		offer(alternating[jdc_pkg::JD_W-1:0]);
		offer(~alternating[jdc_pkg::JD_W-1:0]);
		offer(date_at(64'd1, 64'd0));
		offer(date_at(LAST_DAY, TICKS_PER_DAY - 64'd1));
		// Last Julian-calendar day and first Gregorian day.
		offer(date_at(64'd2299160, 64'd0));
		offer(date_at(64'd2299160, TICKS_PER_DAY - 64'd1));
		offer(date_at(64'd2299161, 64'd0));
		// Around year zero and the start of the year 2000.
		offer(date_at(64'd1721058, 64'd0));
		offer(date_at(64'd1721423, HALF_DAY));
		offer(date_at(64'd2451544, TICKS_PER_DAY - 64'd1));
		offer(date_at(64'd2451545, 64'd0));
		// Leap days: 2000 has one, 1900 does not.
		offer(date_at(64'd2451604, HALF_DAY));
		offer(date_at(64'd2415079, 64'd0));
		offer(date_at(64'd2415080, 64'd0));
		// Seconds rounding up to sixty, and either side of the half-second point.
		offer(date_at(64'd2451545, TICKS_PER_DAY * 64'd596 / 64'd864000));
		offer(date_at(64'd2451545, TICKS_PER_DAY * 64'd5 / 64'd864000));
		offer(date_at(64'd2451545, TICKS_PER_DAY * 64'd5 / 64'd864000 + 64'd1));
		offer(date_at(64'd2451545, TICKS_PER_DAY * 64'd3599 / 64'd86400 - 64'd1));
		drain();

		// Output held off long enough for the pipeline to fill and stall the input.
		rx_mode <= RX_HOLD;
		repeat (HOLD_DATES) offer(random_date());
		drain();

		// Random bursts, alternating stalled and free-running output.
		for (int n = 0; n < RANDOM_DATES; n++) begin
			if (n % PHASE_DATES == 0) begin
				rx_mode <= ((n / PHASE_DATES) % 2 == 0) ? RX_PATTERN : RX_FREE;
			end
			if (n == RANDOM_DATES / 2) drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) pause(gap);
			end
			offer(random_date());
			burst_left--;
		end
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Checked %0d calendar results: %0d dates on the Julian calendar,",
			checked, julian_calendar_dates);
		$display("%0d seconds at sixty; traffic had input bursts, output stalls, %s",
			sixty_seconds, "a long hold-off and drains.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
